// ----- hw/rtl/mma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned ButtonW = 8;

  // Item opcodes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    OP_MOTION = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } op_t;

  // Register map; indices 5..7 are unmapped.
  typedef enum logic [IndexW-1:0] {
    REG_STATUS  = 3'd0,
    REG_X_DATA  = 3'd1,
    REG_Y_DATA  = 3'd2,
    REG_BUTTONS = 3'd3,
    REG_CONTROL = 3'd4
  } reg_idx_t;

  // Status register bit positions.
  localparam int unsigned StatPendingBit = 0;
  localparam int unsigned StatOvfXBit    = 1;
  localparam int unsigned StatOvfYBit    = 2;

  // Control register: interrupt enable.
  localparam int unsigned CtrlIrqEnBit = 0;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IndexW-1:0]       reg_index;
    logic [DataW-1:0]        write_data;
    logic signed [DataW-1:0] delta_x;
    logic signed [DataW-1:0] delta_y;
    logic [ButtonW-1:0]      button_bits;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             access_ok;
    logic             irq_raise;
  } out_item_t;

  typedef struct packed {
    logic             sum;
    logic             ovf;
  } sat_res_flags_t;

endpackage : mma_pkg

`default_nettype wire

// ----- hw/rtl/mouse_motion_accumulator_regs.sv -----
// Each item passes from the input register into the result register and waits
// on out_* until the consumer takes it; out_stall can hold it in either stage.
// Throughput: one item per cycle while out_stall stays low; the input register
// and the result register together work as a two-deep pipe, so stalls on
// out_stall back up into in_stall only once both stages are full. Each axis
// updates by a saturating 33-bit add as the item leaves the input register.
// Reset (rst_n low, synchronous) empties both stages and zeroes the core state.
`timescale 1ns / 1ps
`default_nettype none

module mouse_motion_accumulator_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mma_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mma_pkg::out_item_t out_item
);
  import mma_pkg::*;

  // Input register: holds the item while it is applied to the state.
  logic      s1_valid_r;
  in_item_t  s1_item_r;

  // Result register: holds a finished item until the consumer takes it.
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      advance;
  logic      in_fire;
  out_item_t core_result;

  // Move the input-stage item forward when the result register is free or
  // drains in this same cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  // Stall the sender only when the input stage is full and cannot advance.
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  mma_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |-> in_stall && !advance)
    else $error("pipe advanced into a stalled result register");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty input stage");
`endif

endmodule : mouse_motion_accumulator_regs

`default_nettype wire

// ----- hw/rtl/mma_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mma_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mma_pkg::in_item_t  item,
  output mma_pkg::out_item_t result
);
  import mma_pkg::*;

  logic signed [DataW-1:0] sum_x_r, sum_x_nxt;
  logic signed [DataW-1:0] sum_y_r, sum_y_nxt;
  logic                    ovf_x_r, ovf_x_nxt;
  logic                    ovf_y_r, ovf_y_nxt;
  logic [ButtonW-1:0]      buttons_r, buttons_nxt;
  logic [DataW-1:0]        control_r, control_nxt;

  logic signed [DataW:0]   add_x, add_y;
  logic signed [DataW-1:0] sat_x, sat_y;
  logic                    clip_x, clip_y;
  logic [DataW-1:0]        status_word;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // Saturating adds: overflow when the two top bits of the wide sum disagree.
  always_comb begin
    add_x  = {sum_x_r[DataW-1], sum_x_r} + {item.delta_x[DataW-1], item.delta_x};
    add_y  = {sum_y_r[DataW-1], sum_y_r} + {item.delta_y[DataW-1], item.delta_y};
    clip_x = add_x[DataW] != add_x[DataW-1];
    clip_y = add_y[DataW] != add_y[DataW-1];
    sat_x  = clip_x ? (add_x[DataW] ? SatMin : SatMax) : add_x[DataW-1:0];
    sat_y  = clip_y ? (add_y[DataW] ? SatMin : SatMax) : add_y[DataW-1:0];
  end

  always_comb begin
    status_word                 = '0;
    status_word[StatPendingBit] = (sum_x_r != '0) || (sum_y_r != '0);
    status_word[StatOvfXBit]    = ovf_x_r;
    status_word[StatOvfYBit]    = ovf_y_r;
  end

  always_comb begin
    sum_x_nxt   = sum_x_r;
    sum_y_nxt   = sum_y_r;
    ovf_x_nxt   = ovf_x_r;
    ovf_y_nxt   = ovf_y_r;
    buttons_nxt = buttons_r;
    control_nxt = control_r;
    result      = '0;
    case (item.opcode)
      OP_MOTION: begin
        sum_x_nxt        = sat_x;
        sum_y_nxt        = sat_y;
        ovf_x_nxt        = ovf_x_r | clip_x;
        ovf_y_nxt        = ovf_y_r | clip_y;
        buttons_nxt      = item.button_bits;
        result.access_ok = 1'b1;
        result.irq_raise = control_r[CtrlIrqEnBit];
      end
      OP_READ: begin
        result.access_ok = 1'b1;
        unique case (item.reg_index)
          REG_STATUS:  result.read_data = status_word;
          REG_X_DATA: begin
            result.read_data = sum_x_r;
            sum_x_nxt        = '0;
            ovf_x_nxt        = 1'b0;
          end
          REG_Y_DATA: begin
            result.read_data = sum_y_r;
            sum_y_nxt        = '0;
            ovf_y_nxt        = 1'b0;
          end
          REG_BUTTONS: result.read_data = {{(DataW-ButtonW){1'b0}}, buttons_r};
          REG_CONTROL: result.read_data = control_r;
          default:     result.access_ok = 1'b0;
        endcase
      end
      OP_WRITE: begin
        if (item.reg_index == REG_CONTROL) begin
          control_nxt      = item.write_data;
          result.access_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      ovf_x_r   <= 1'b0;
      ovf_y_r   <= 1'b0;
      buttons_r <= '0;
      control_r <= '0;
    end else if (fire) begin
      sum_x_r   <= sum_x_nxt;
      sum_y_r   <= sum_y_nxt;
      ovf_x_r   <= ovf_x_nxt;
      ovf_y_r   <= ovf_y_nxt;
      buttons_r <= buttons_nxt;
      control_r <= control_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_read_x_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_READ && item.reg_index == REG_X_DATA
    |=> sum_x_r == '0 && !ovf_x_r)
    else $error("X read did not clear accumulator and flag");

  a_irq_only_motion: assert property (@(posedge clk) disable iff (!rst_n)
    result.irq_raise |-> item.opcode == OP_MOTION && control_r[CtrlIrqEnBit])
    else $error("interrupt outside an enabled motion item");

  a_state_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(sum_x_r) && $stable(sum_y_r) && $stable(control_r))
    else $error("state changed without an item");

  a_clip_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_MOTION && clip_y |=> ovf_y_r)
    else $error("Y saturation did not set its flag");
`endif

endmodule : mma_core

`default_nettype wire
